FILE: rtl/recency_order_tracker_defines.svh
// Assertion shorthands for the recency order tracker checks.
`ifndef RECENCY_ORDER_TRACKER_DEFINES_SVH
`define RECENCY_ORDER_TRACKER_DEFINES_SVH

// Check that is switched off while reset is held.
`define ROT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that also looks at the reset itself.
`define ROT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/rot_pkg.sv
`timescale 1ns / 1ps

package rot_pkg;

    localparam int MAX_VALUES  = 64;
    localparam int MAX_GROUP   = 8;

    localparam int VAL_W       = $clog2(MAX_VALUES + 1);
    localparam int POS_W       = $clog2(MAX_VALUES);
    localparam int CNT_W       = $clog2(MAX_GROUP + 1);
    localparam int TAIL_IW     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    localparam int NUM_W       = 7;
    localparam int GSZ_W       = 4;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VALUES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE = 1'b1;

    localparam logic [NUM_W-1:0] NUM_RESET = 7'd50;
    localparam logic [GSZ_W-1:0] GSZ_RESET = 4'd5;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EMIT,
        S_CMP_MAIN,
        S_CMP_TAIL,
        S_CMP_DRAIN
    } t_state;

endpackage

FILE: rtl/rot_ram.sv
`timescale 1ns / 1ps

module rot_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 7
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/recency_order_tracker.sv
`timescale 1ns / 1ps

// Channel   | Dir | Handshake                  | Payload
// ----------+-----+----------------------------+------------------------------------
// s (touch) | in  | i_s_tvalid / o_s_tready    | i_s_tdata[6:0] touched_value
// m (pos)   | out | o_m_tvalid / i_m_tready    | o_m_tdata[5:0] prior_position
// cfg       | in  | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// A touch goes through three steps: accept, position lookup, result and update.
// The touch that closes a group adds a compaction walk: the n values read
// one a cycle from the list memory, then the g group slots, then a drain
// step that writes back the last slot.
// Reset and every register write start a clearing pass over all 64 entries
// that rewrites both memories; no touch is taken during it.
// A result waits in the output register; only the next result stalls on it.

module recency_order_tracker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // touch beats: [6:0] touched_value, [7] zero
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [rot_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // result beats: [5:0] prior_position, [7:6] zero
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [rot_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // register writes
    input  logic                               i_cfg_we,
    input  logic [rot_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rot_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import rot_pkg::*;

    // registers
    t_state             r_state, n_state;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [GSZ_W-1:0]   r_gsz, n_gsz;
    logic [VAL_W-1:0]   r_ci, n_ci;     // sweep / walk counter
    logic [VAL_W-1:0]   r_w, n_w;       // compaction write pointer
    logic [CNT_W-1:0]   r_cnt, n_cnt;   // touches in the open group
    logic [VAL_W-1:0]   r_tail [MAX_GROUP];
    logic [VAL_W-1:0]   n_tail [MAX_GROUP];
    logic [VAL_W-1:0]   r_v, n_v;
    logic               r_v_ok, n_v_ok;
    logic [POS_W-1:0]   r_p, n_p;
    logic               r_b_valid, n_b_valid;
    logic               r_b_tail, n_b_tail;
    logic [VAL_W-1:0]   r_b_val, n_b_val;
    logic               r_out_valid, n_out_valid;
    logic [POS_W-1:0]   r_out_pos, n_out_pos;

    // memory ports
    logic               list_we;
    logic [POS_W-1:0]   list_waddr, list_raddr;
    logic [VAL_W-1:0]   list_wdata, list_rdata;
    logic               pos_we;
    logic [POS_W-1:0]   pos_waddr, pos_raddr;
    logic [POS_W-1:0]   pos_wdata, pos_rdata;

    // derived
    logic [VAL_W-1:0]   n_eff;
    logic [CNT_W-1:0]   g_eff;
    logic [VAL_W-1:0]   in_v;
    logic               s_accept;
    logic               out_free;
    logic               clear_last, main_last, tail_last, group_full;
    logic [CNT_W-1:0]   cnt_inc;
    logic [MAX_GROUP-1:0] match;
    logic               found;
    logic [VAL_W-1:0]   sb_val;

    rot_ram #(.DEPTH(MAX_VALUES), .WIDTH(VAL_W)) u_list (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_waddr),
        .i_wdata (list_wdata),
        .i_raddr (list_raddr),
        .o_rdata (list_rdata)
    );

    rot_ram #(.DEPTH(MAX_VALUES), .WIDTH(POS_W)) u_pos (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    // clamp the registers to their working range
    always_comb begin
        if (int'(r_num) < 2) begin
            n_eff = VAL_W'(2);
        end else if (int'(r_num) > MAX_VALUES) begin
            n_eff = VAL_W'(MAX_VALUES);
        end else begin
            n_eff = VAL_W'(r_num);
        end
        if (int'(r_gsz) < 1) begin
            g_eff = CNT_W'(1);
        end else if (int'(r_gsz) > MAX_GROUP) begin
            g_eff = CNT_W'(MAX_GROUP);
        end else begin
            g_eff = CNT_W'(r_gsz);
        end
    end

    assign in_v       = i_s_tdata[VAL_W-1:0];
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign clear_last = (r_ci == VAL_W'(MAX_VALUES - 1));
    assign main_last  = (r_ci == n_eff - VAL_W'(1));
    assign tail_last  = (r_ci[TAIL_IW-1:0] == TAIL_IW'(g_eff - CNT_W'(1)));
    assign cnt_inc    = r_cnt + CNT_W'(1);
    assign group_full = (cnt_inc >= g_eff);
    assign sb_val     = r_b_tail ? r_b_val : list_rdata;

    // repeat of this value earlier in the open group
    always_comb begin
        for (int k = 0; k < MAX_GROUP; k++) begin
            match[k] = (r_tail[k] == r_v);
        end
        found = |match;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:     if (clear_last) n_state = S_IDLE;
            S_IDLE:      if (s_accept) n_state = S_READ;
            S_READ:      n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = (r_v_ok && group_full) ? S_CMP_MAIN : S_IDLE;
                end
            end
            S_CMP_MAIN:  if (main_last) n_state = S_CMP_TAIL;
            S_CMP_TAIL:  if (tail_last) n_state = S_CMP_DRAIN;
            S_CMP_DRAIN: n_state = S_IDLE;
            default:     n_state = S_CLEAR;
        endcase
        // a register write restarts the order from any state
        if (i_cfg_we) begin
            n_state = S_CLEAR;
        end
    end

    // datapath and memory controls
    always_comb begin
        n_num       = r_num;
        n_gsz       = r_gsz;
        n_ci        = r_ci;
        n_w         = r_w;
        n_cnt       = r_cnt;
        n_tail      = r_tail;
        n_v         = r_v;
        n_v_ok      = r_v_ok;
        n_p         = r_p;
        n_b_valid   = 1'b0;
        n_b_tail    = 1'b0;
        n_b_val     = r_b_val;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_pos   = r_out_pos;

        list_we     = 1'b0;
        list_waddr  = r_w[POS_W-1:0];
        list_wdata  = sb_val;
        list_raddr  = r_ci[POS_W-1:0];
        pos_we      = 1'b0;
        pos_waddr   = POS_W'(sb_val - VAL_W'(1));
        pos_wdata   = r_w[POS_W-1:0];
        pos_raddr   = POS_W'(in_v - VAL_W'(1));

        unique case (r_state)
            S_CLEAR: begin
                // ascending list, identity positions
                list_we    = 1'b1;
                list_waddr = r_ci[POS_W-1:0];
                list_wdata = r_ci + VAL_W'(1);
                pos_we     = 1'b1;
                pos_waddr  = r_ci[POS_W-1:0];
                pos_wdata  = r_ci[POS_W-1:0];
                n_ci       = r_ci + VAL_W'(1);
            end
            S_IDLE: begin
                if (s_accept) begin
                    n_v    = in_v;
                    n_v_ok = (in_v != '0) && (in_v <= n_eff);
                end
            end
            S_READ: begin
                n_p = pos_rdata;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pos   = r_v_ok ? r_p : '0;
                    if (r_v_ok) begin
                        // drop the earlier group place, or the old list slot
                        for (int k = 0; k < MAX_GROUP; k++) begin
                            if (match[k]) n_tail[k] = '0;
                        end
                        n_tail[r_cnt[TAIL_IW-1:0]] = r_v;
                        n_cnt = cnt_inc;
                        if (!found) begin
                            list_we    = 1'b1;
                            list_waddr = r_p;
                            list_wdata = '0;
                        end
                        if (group_full) begin
                            n_ci = '0;
                            n_w  = '0;
                        end
                    end
                end
            end
            S_CMP_MAIN: begin
                n_b_valid = 1'b1;
                n_ci      = main_last ? '0 : r_ci + VAL_W'(1);
            end
            S_CMP_TAIL: begin
                n_b_valid = 1'b1;
                n_b_tail  = 1'b1;
                n_b_val   = r_tail[r_ci[TAIL_IW-1:0]];
                n_ci      = r_ci + VAL_W'(1);
            end
            S_CMP_DRAIN: begin
                for (int k = 0; k < MAX_GROUP; k++) begin
                    n_tail[k] = '0;
                end
                n_cnt = '0;
            end
            default: ;
        endcase

        // compaction write stage: keep non-empty slots in order
        if (r_b_valid && sb_val != '0) begin
            list_we = 1'b1;
            pos_we  = 1'b1;
            n_w     = r_w + VAL_W'(1);
        end

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NUM_VALUES: n_num = i_cfg_data[NUM_W-1:0];
                CFG_GROUP_SIZE: n_gsz = i_cfg_data[GSZ_W-1:0];
                default: ;
            endcase
            n_ci  = '0;
            n_cnt = '0;
            for (int k = 0; k < MAX_GROUP; k++) begin
                n_tail[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_num       <= NUM_RESET;
            r_gsz       <= GSZ_RESET;
            r_ci        <= '0;
            r_w         <= '0;
            r_cnt       <= '0;
            r_b_valid   <= 1'b0;
            r_b_tail    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_GROUP; k++) begin
                r_tail[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_num       <= n_num;
            r_gsz       <= n_gsz;
            r_ci        <= n_ci;
            r_w         <= n_w;
            r_cnt       <= n_cnt;
            r_b_valid   <= n_b_valid;
            r_b_tail    <= n_b_tail;
            r_out_valid <= n_out_valid;
            r_tail      <= n_tail;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_v       <= n_v;
        r_v_ok    <= n_v_ok;
        r_p       <= n_p;
        r_b_val   <= n_b_val;
        r_out_pos <= n_out_pos;
    end

    // outputs
    always_comb begin
        o_s_tready = (r_state == S_IDLE);
        o_m_tvalid = r_out_valid;
        o_m_tdata  = OUT_TDATA_W'(r_out_pos);
    end

endmodule

FILE: rtl/rot_checker.sv
`timescale 1ns / 1ps

`include "recency_order_tracker_defines.svh"

module rot_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [rot_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input logic                               i_cfg_we
);

    // a waiting result holds until taken
    `ROT_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata), "result beat dropped or changed while stalled")

    // reset empties the output and starts the clearing pass
    `ROT_ASSERT_RST(a_rst_quiet, !i_rst_n |=> !o_m_tvalid && !o_s_tready, "beat offered straight after reset")

    // one touch at a time: the beat after an accept is never taken at once
    `ROT_ASSERT(a_one_at_a_time, i_s_tvalid && o_s_tready |=> !o_s_tready, "second touch taken before lookup")

    // a register write restarts the order, so no touch is taken next cycle
    `ROT_ASSERT(a_cfg_restart, i_cfg_we |=> !o_s_tready, "touch taken during restart")

endmodule

bind recency_order_tracker rot_checker u_rot_checker (.*);

FILE: verif/recency_order_tracker_tb.sv
`timescale 1ns / 1ps

module recency_order_tracker_tb;

    import rot_pkg::*;

    localparam int LIST_DEPTH  = MAX_VALUES + MAX_GROUP;
    // Let any compaction walk finish before a register write.
    localparam int SETTLE_CYC  = 100;
    localparam int CYCLE_LIMIT = 1_500_000;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_s_tvalid;
    logic                        o_s_tready;
    logic [IN_TDATA_W-1:0]       i_s_tdata;
    logic                        o_m_tvalid;
    logic                        i_m_tready;
    logic [OUT_TDATA_W-1:0]      o_m_tdata;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_DATA_W-1:0]       i_cfg_data;

    recency_order_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Recency predictor: own copy of the list, the pre-group positions
    // and the open group count, plus the two registers as last written.
    // ------------------------------------------------------------------
    logic [NUM_W-1:0] num_reg;
    logic [GSZ_W-1:0] gsz_reg;
    logic [VAL_W-1:0] slot_val  [LIST_DEPTH];
    logic [VAL_W-1:0] value_pos [MAX_VALUES];
    int               open_count;

    // Registers are used clamped to their meaningful range.
    function automatic int eff_values();
        int n;
        n = num_reg;
        if (n < 2) n = 2;
        if (n > MAX_VALUES) n = MAX_VALUES;
        return n;
    endfunction

    function automatic int eff_group();
        int g;
        g = gsz_reg;
        if (g < 1) g = 1;
        if (g > MAX_GROUP) g = MAX_GROUP;
        return g;
    endfunction

    // Back to ascending order, identity positions, no open group.
    function automatic void restart_recency();
        int n;
        n = eff_values();
        for (int i = 0; i < LIST_DEPTH; i++) slot_val[i] = '0;
        for (int i = 0; i < MAX_VALUES; i++) begin
            value_pos[i] = VAL_W'(i);
            if (i < n) slot_val[i] = VAL_W'(i + 1);
        end
        open_count = 0;
    endfunction

    // Stable squeeze of the first span slots; positions refresh here only.
    function automatic void compact_list(int span);
        int               w;
        logic [VAL_W-1:0] v;
        w = 0;
        for (int r = 0; r < span; r++) begin
            v = slot_val[r];
            if (v != '0) begin
                slot_val[w] = v;
                value_pos[v - 1] = VAL_W'(w);
                w++;
            end
        end
        for (; w < span; w++) slot_val[w] = '0;
        open_count = 0;
    endfunction

    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_NUM_VALUES) begin
            num_reg = data[NUM_W-1:0];
        end else if (idx == CFG_GROUP_SIZE) begin
            gsz_reg = data[GSZ_W-1:0];
        end
        restart_recency();
    endfunction

    // Position held before the open group; moves the value to the tail.
    function automatic logic [POS_W-1:0] track_touch(logic [VAL_W-1:0] v);
        int n;
        int g;
        int p;
        bit hit;
        n   = eff_values();
        g   = eff_group();
        hit = 1'b0;
        // Out-of-range touch: report zero and leave everything alone.
        if (v < 1 || v > n) return '0;
        p = value_pos[v - 1];
        if (open_count >= g) open_count = 0;
        // A repeat in the group vacates its earlier tail place.
        for (int k = 0; k < open_count; k++) begin
            if (slot_val[n + k] == v) begin
                slot_val[n + k] = '0;
                hit = 1'b1;
            end
        end
        if (!hit && p < n + g) slot_val[p] = '0;
        slot_val[n + open_count] = v;
        open_count++;
        if (open_count >= g) compact_list(n + g);
        return POS_W'(p);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus store, expected positions and idling controls.
    // ------------------------------------------------------------------
    logic [VAL_W-1:0] touch_q[$];
    logic [POS_W-1:0] prior_pos_q[$];
    logic [VAL_W-1:0] recent_q[$];
    int               send_idle_pct;
    int               recv_idle_pct;
    int               err_count;
    int               cycle_count;
    logic             touch_beat;

    // ------------------------------------------------------------------
    // Touch driver: change inputs on the falling edge; advance to the next
    // beat only once the current one was taken at the last rising edge.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_s_tvalid || touch_beat) begin
            if (i_rst_n && touch_q.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                i_s_tdata  <= IN_TDATA_W'(touch_q.pop_front());
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure, redrawn every cycle.
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: sample on the rising edge, predict on every accepted touch
    // beat, check every accepted result beat against the oldest entry.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("recency_order_tracker_tb: errors");
            $finish;
        end else begin
            touch_beat <= i_s_tvalid && o_s_tready;
            if (i_rst_n && i_cfg_we) apply_setting(i_cfg_index, i_cfg_data);
            if (i_rst_n && i_s_tvalid && o_s_tready)
                prior_pos_q.push_back(track_touch(i_s_tdata[VAL_W-1:0]));
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (prior_pos_q.size() == 0) begin
                    if (err_count < 10)
                        $display("unexpected result beat: tdata %0h", o_m_tdata);
                    err_count <= err_count + 1;
                end else if (o_m_tdata !== OUT_TDATA_W'(prior_pos_q[0])) begin
                    if (err_count < 10)
                        $display("prior_position mismatch: expected %0d, got %0d (tdata %0h)",
                                 prior_pos_q[0], o_m_tdata[POS_W-1:0], o_m_tdata);
                    err_count <= err_count + 1;
                    void'(prior_pos_q.pop_front());
                end else begin
                    void'(prior_pos_q.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencing helpers.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Hold until every touch is out and every result back, then let any
    // trailing compaction walk run out.
    task automatic drain_and_settle();
        while (touch_q.size() != 0 || i_s_tvalid || prior_pos_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Mostly in-range touches, a fair share of repeats of recent values so
    // that groups hold duplicates, and some out-of-range noise.
    task automatic queue_touches(input int count);
        int               n;
        int               r;
        logic [VAL_W-1:0] v;
        n = eff_values();
        recent_q.delete();
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 4) begin
                v = '0;
            end else if (r < 10) begin
                v = VAL_W'($urandom_range(127, n + 1));
            end else if (r < 32 && recent_q.size() != 0) begin
                v = recent_q[$urandom_range(recent_q.size() - 1)];
            end else begin
                v = VAL_W'($urandom_range(n, 1));
            end
            touch_q.push_back(v);
            recent_q.push_back(v);
            if (recent_q.size() > 6) void'(recent_q.pop_front());
        end
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] nv,
                             input logic [CFG_DATA_W-1:0] gs,
                             input int count);
        drain_and_settle();
        write_reg(CFG_NUM_VALUES, nv);
        write_reg(CFG_GROUP_SIZE, gs);
        queue_touches(count);
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_m_tready    = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_NUM_VALUES;
        i_cfg_data    = '0;
        touch_beat    = 1'b0;
        err_count     = 0;
        cycle_count   = 0;
        num_reg       = NUM_RESET;
        gsz_reg       = GSZ_RESET;
        restart_recency();

        // Sender rarely idles, receiver idles about half the time.
        send_idle_pct = 8;
        recv_idle_pct = 54;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, reset settings (50 values, groups of 5).
        // Lowest and highest value, one value touched three times in a group.
        touch_q.push_back(7'd1);
        touch_q.push_back(7'd50);
        touch_q.push_back(7'd1);
        touch_q.push_back(7'd25);
        touch_q.push_back(7'd1);
        // Zero, just above range, all-ones and 64: ignored, result zero.
        touch_q.push_back(7'd0);
        touch_q.push_back(7'd51);
        touch_q.push_back(7'd127);
        touch_q.push_back(7'd2);
        touch_q.push_back(7'd3);
        touch_q.push_back(7'd50);
        touch_q.push_back(7'd64);
        touch_q.push_back(7'd49);
        touch_q.push_back(7'd10);
        // The same value for a whole group.
        repeat (5) touch_q.push_back(7'd50);
        // Leave a group open; the next register write must drop it.
        touch_q.push_back(7'd7);
        touch_q.push_back(7'd8);

        // Widest list, largest groups.
        run_phase(7'd64, 7'd8, 230);
        // Smallest list, compaction after every touch.
        run_phase(7'd2, 7'd1, 200);

        // Swap the idling: sender mostly idle, receiver rarely.
        drain_and_settle();
        send_idle_pct = 54;
        recv_idle_pct = 8;
        // A below-range value count clamps up, an over-range group size clamps down.
        run_phase(7'd0, 7'd15, 180);
        // Full-width count clamps to the widest list; group size zero to one.
        run_phase(7'd127, 7'd0, 150);
        // Only the low four bits of the group size register count.
        run_phase(7'd1, 7'h7A, 150);

        // No idling on either side.
        drain_and_settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(CFG_DATA_W'($urandom_range(MAX_VALUES, 2)),
                  CFG_DATA_W'($urandom_range(MAX_GROUP, 1)), 220);
        // One register rewritten on its own.
        drain_and_settle();
        write_reg(CFG_GROUP_SIZE, 7'd3);
        queue_touches(60);
        run_phase(7'd33, 7'd3, 140);

        drain_and_settle();
        if (err_count == 0 && prior_pos_q.size() == 0) begin
            $display("recency_order_tracker_tb: clean");
        end else begin
            $display("recency_order_tracker_tb: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/rot_pkg.sv
rtl/rot_ram.sv
rtl/recency_order_tracker.sv
rtl/rot_checker.sv
verif/recency_order_tracker_tb.sv
